// File: design/rta_pkg.sv
// Shared constants, record types, saturation helpers and a task-number helper for the
// response-time analysis block. No dependencies.
package rta_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;

  localparam int FIELD_W  = 16;
  localparam int COUNT_W  = 8;
  localparam int NUM_W    = 5;
  localparam int RESP_W   = 32;
  localparam int IDX_W    = $clog2(MAX_TASKS);
  localparam int CNT_W    = $clog2(MAX_TASKS + 1);
  localparam int SW2_W    = TIME_BITS + 1;
  localparam int ESW_W    = TIME_BITS + 2;
  localparam int NPX_W    = TIME_BITS + 2;
  localparam int BLK_W    = (NPX_W > RESP_W) ? NPX_W : RESP_W;
  localparam int SSUM_W   = TIME_BITS + CNT_W;
  localparam int ACC_W    = RESP_W + 1;
  localparam int WIDE_W   = TIME_BITS + 36;
  localparam int TIMING_W = IDX_W + 4 * TIME_BITS;
  localparam int SUSP_W   = 2 * TIME_BITS + COUNT_W;

  localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {RESP_W{1'b0}}};

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] exec;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] sw;
  } timing_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] susp;
    logic [COUNT_W-1:0]   count;
    logic [TIME_BITS-1:0] np;
  } susp_t;

  // clamp a sum to one above the 32-bit maximum; sticky saturation marker
  function automatic logic [ACC_W-1:0] clamp(input logic [WIDE_W-1:0] v);
    logic [ACC_W-1:0] res;
    res = (v > WIDE_W'(ACC_CAP)) ? ACC_CAP : v[ACC_W-1:0];
    return res;
  endfunction

  function automatic logic [RESP_W-1:0] sat32(input logic [ACC_W-1:0] v);
    logic [RESP_W-1:0] res;
    res = v[RESP_W] ? {RESP_W{1'b1}} : v[RESP_W-1:0];
    return res;
  endfunction

  function automatic logic [NUM_W-1:0] task_num(input logic [IDX_W-1:0] idx);
    logic [31:0] tmp;
    tmp = 32'(idx) + 32'd1;
    return tmp[NUM_W-1:0];
  endfunction

endpackage

// File: design/rta_if.sv
// Input and result channel interfaces of the response-time analysis block.
// Depends on rta_pkg.
interface rta_in_if import rta_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] task_period;
  logic [FIELD_W-1:0] exec_time;
  logic [FIELD_W-1:0] rel_deadline;
  logic [FIELD_W-1:0] suspend_time;
  logic [COUNT_W-1:0] suspend_count;
  logic [FIELD_W-1:0] nonpreempt_len;
  logic [FIELD_W-1:0] switch_time;
  logic               last_task;

  modport source(output valid, task_period, exec_time, rel_deadline, suspend_time,
                 suspend_count, nonpreempt_len, switch_time, last_task,
                 input ready);
  modport sink(input valid, task_period, exec_time, rel_deadline, suspend_time,
               suspend_count, nonpreempt_len, switch_time, last_task,
               output ready);
endinterface

interface rta_out_if import rta_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NUM_W-1:0]  task_number;
  logic [RESP_W-1:0] response_time;
  logic [RESP_W-1:0] blocking_time;
  logic              deadline_missed;
  logic              last_result;

  modport source(output valid, task_number, response_time, blocking_time,
                 deadline_missed, last_result, input ready);
  modport sink(input valid, task_number, response_time, blocking_time,
               deadline_missed, last_result, output ready);
endinterface

// File: design/rta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/rta_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, 32-bit dividend.
// Depends on rta_pkg.
module rta_div import rta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RESP_W-1:0]    dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic                 done,
  output logic [RESP_W-1:0]    quotient,
  output logic                 rem_nz
);
  localparam int STEP_W = $clog2(RESP_W + 1);

  logic                 busy_r, done_r;
  logic [STEP_W-1:0]    cnt_r;
  logic [RESP_W-1:0]    a_r;
  logic [TIME_BITS-1:0] rem_r, den_r;
  logic [TIME_BITS:0]   rem_sh, den_ext, rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_r, a_r[RESP_W-1]};
  assign den_ext = {1'b0, den_r};
  assign ge      = rem_sh >= den_ext;
  assign rem_sub = rem_sh - den_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(RESP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      a_r   <= {a_r[RESP_W-2:0], ge};
      rem_r <= ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = a_r;
  assign rem_nz   = rem_r != '0;
endmodule

// File: design/response_time_analysis.sv
// Fixed-priority response-time analysis with blocking; depends on rta_pkg,
// rta_if, rta_ram and rta_div.
// Load: each record is inserted in deadline order, shifting every stored entry with
// a later deadline; an entry with an earlier or equal deadline stops the shift.
// Analysis: blocking terms for all tasks first, then per task k a start sum and
// per iteration k divisions on the 32-step divider, up to each result.
// Reset (rst_n, synchronous) clears control only; stores are undefined until written.
module response_time_analysis import rta_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  rta_in_if.sink  in_if,
  rta_out_if.source out_if
);
  typedef enum logic [19:0] {
    S_LOAD   = 20'h00001, S_SH_RD  = 20'h00002, S_SH_WR  = 20'h00004,
    S_SH_PUT = 20'h00008, S_A_RD   = 20'h00010, S_A_WR   = 20'h00020,
    S_B_RD   = 20'h00040, S_B_MUL  = 20'h00080, S_B_WR   = 20'h00100,
    S_R_RD   = 20'h00200, S_R_HDR  = 20'h00400, S_I_RD   = 20'h00800,
    S_I_ADD  = 20'h01000, S_T_START = 20'h02000, S_J_RD  = 20'h04000,
    S_J_DIV  = 20'h08000, S_J_WAIT = 20'h10000, S_J_ADD  = 20'h20000,
    S_CHECK  = 20'h40000, S_EMIT   = 20'h80000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt, j_r, j_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  timing_t              new_tim_r, new_tim_nxt;
  susp_t                new_sus_r, new_sus_nxt;
  logic                 last_r, last_nxt;
  logic [NPX_W-1:0]     mx_r, mx_nxt;
  logic [SSUM_W-1:0]    ssum_r, ssum_nxt;
  logic [WIDE_W-1:0]    prod_r, prod_nxt;
  logic [TIME_BITS-1:0] ek_r, ek_nxt, dl_r, dl_nxt;
  logic [SW2_W-1:0]     sw2_r, sw2_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [RESP_W-1:0]    bk_r, bk_nxt, t_r, t_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ESW_W-1:0]     esw_r, esw_nxt;
  logic                 ov_r, ov_nxt;
  logic [NUM_W-1:0]     on_r, on_nxt;
  logic [RESP_W-1:0]    ors_r, ors_nxt, obk_r, obk_nxt;
  logic                 omiss_r, omiss_nxt, olast_r, olast_nxt;

  logic                 tim_we, sus_we, blk_we;
  logic [IDX_W-1:0]     tim_wa, sus_wa, blk_wa, tim_ra, sus_ra, blk_ra;
  logic [TIMING_W-1:0]  tim_wd, tim_q;
  logic [SUSP_W-1:0]    sus_wd, sus_q;
  logic [BLK_W-1:0]     blk_wd, blk_q;
  timing_t              tim_rd;
  susp_t                sus_rd;

  logic                 div_start, div_done, div_rnz;
  logic [TIME_BITS-1:0] div_den;
  logic [RESP_W-1:0]    div_q;

  logic [NPX_W-1:0]     npx;
  logic [RESP_W-1:0]    r_cur;
  logic [COUNT_W:0]     cnt1;
  logic [ACC_W-1:0]     ceil_q;

  assign tim_rd = timing_t'(tim_q);
  assign sus_rd = susp_t'(sus_q);
  assign npx    = NPX_W'(sus_rd.np) + NPX_W'({tim_rd.sw, 1'b0});
  assign r_cur  = sat32(acc_r);
  assign cnt1   = (COUNT_W + 1)'(sus_rd.count) + (COUNT_W + 1)'(1);
  assign ceil_q = ACC_W'(div_q) + ACC_W'(div_rnz);

  rta_ram #(.WIDTH(TIMING_W), .DEPTH(MAX_TASKS)) u_timing_store (
    .clk, .we(tim_we), .waddr(tim_wa), .wdata(tim_wd), .raddr(tim_ra), .rdata(tim_q)
  );
  rta_ram #(.WIDTH(SUSP_W), .DEPTH(MAX_TASKS)) u_suspension_store (
    .clk, .we(sus_we), .waddr(sus_wa), .wdata(sus_wd), .raddr(sus_ra), .rdata(sus_q)
  );
  rta_ram #(.WIDTH(BLK_W), .DEPTH(MAX_TASKS)) u_blocking_store (
    .clk, .we(blk_we), .waddr(blk_wa), .wdata(blk_wd), .raddr(blk_ra), .rdata(blk_q)
  );

  rta_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(t_r), .divisor(div_den),
    .done(div_done), .quotient(div_q), .rem_nz(div_rnz)
  );

  assign in_if.ready            = state_r == S_LOAD;
  assign out_if.valid           = ov_r;
  assign out_if.task_number     = on_r;
  assign out_if.response_time   = ors_r;
  assign out_if.blocking_time   = obk_r;
  assign out_if.deadline_missed = omiss_r;
  assign out_if.last_result     = olast_r;

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    new_tim_nxt = new_tim_r;
    new_sus_nxt = new_sus_r;
    last_nxt    = last_r;
    mx_nxt      = mx_r;
    ssum_nxt    = ssum_r;
    prod_nxt    = prod_r;
    ek_nxt      = ek_r;
    dl_nxt      = dl_r;
    sw2_nxt     = sw2_r;
    idx_nxt     = idx_r;
    bk_nxt      = bk_r;
    t_nxt       = t_r;
    acc_nxt     = acc_r;
    esw_nxt     = esw_r;
    ov_nxt      = ov_r;
    on_nxt      = on_r;
    ors_nxt     = ors_r;
    obk_nxt     = obk_r;
    omiss_nxt   = omiss_r;
    olast_nxt   = olast_r;
    tim_we      = 1'b0;
    sus_we      = 1'b0;
    blk_we      = 1'b0;
    tim_wa      = IDX_W'(j_r);
    sus_wa      = IDX_W'(j_r);
    blk_wa      = k_r;
    tim_wd      = tim_rd;
    sus_wd      = sus_rd;
    blk_wd      = '0;
    tim_ra      = k_r;
    sus_ra      = k_r;
    blk_ra      = k_r;
    div_start   = 1'b0;
    div_den     = (tim_rd.period == '0) ? TIME_BITS'(1) : tim_rd.period;

    unique case (state_r)
      S_LOAD: begin
        if (in_if.valid) begin
          new_tim_nxt.idx      = n_r[IDX_W-1:0];
          new_tim_nxt.period   = TIME_BITS'(in_if.task_period);
          new_tim_nxt.exec     = TIME_BITS'(in_if.exec_time);
          new_tim_nxt.deadline = TIME_BITS'(in_if.rel_deadline);
          new_tim_nxt.sw       = TIME_BITS'(in_if.switch_time);
          new_sus_nxt.susp     = TIME_BITS'(in_if.suspend_time);
          new_sus_nxt.count    = in_if.suspend_count;
          new_sus_nxt.np       = TIME_BITS'(in_if.nonpreempt_len);
          last_nxt             = in_if.last_task;
          if (n_r < CNT_W'(MAX_TASKS)) begin
            j_nxt     = n_r;
            state_nxt = (n_r == '0) ? S_SH_PUT : S_SH_RD;
          end else if (in_if.last_task) begin
            k_nxt     = IDX_W'(n_r - CNT_W'(1));
            mx_nxt    = '0;
            state_nxt = S_A_RD;
          end
        end
      end
      S_SH_RD: begin
        tim_ra    = IDX_W'(j_r - CNT_W'(1));
        sus_ra    = IDX_W'(j_r - CNT_W'(1));
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        if (tim_rd.deadline > new_tim_r.deadline) begin
          tim_we    = 1'b1;
          sus_we    = 1'b1;
          j_nxt     = j_r - CNT_W'(1);
          state_nxt = (j_r == CNT_W'(1)) ? S_SH_PUT : S_SH_RD;
        end else begin
          state_nxt = S_SH_PUT;
        end
      end
      S_SH_PUT: begin
        tim_we = 1'b1;
        sus_we = 1'b1;
        tim_wd = new_tim_r;
        sus_wd = new_sus_r;
        n_nxt  = n_r + CNT_W'(1);
        if (last_r) begin
          k_nxt     = IDX_W'(n_r);
          mx_nxt    = '0;
          state_nxt = S_A_RD;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_A_RD: state_nxt = S_A_WR;
      S_A_WR: begin
        blk_we = 1'b1;
        blk_wd = BLK_W'(mx_r);
        mx_nxt = (npx > mx_r) ? npx : mx_r;
        if (k_r == '0) begin
          ssum_nxt  = '0;
          state_nxt = S_B_RD;
        end else begin
          k_nxt     = k_r - IDX_W'(1);
          state_nxt = S_A_RD;
        end
      end
      S_B_RD: state_nxt = S_B_MUL;
      S_B_MUL: begin
        ssum_nxt  = ssum_r + SSUM_W'(sus_rd.susp);
        prod_nxt  = WIDE_W'(cnt1) * WIDE_W'(blk_q[NPX_W-1:0]);
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        blk_we = 1'b1;
        blk_wd = BLK_W'(sat32(clamp(WIDE_W'(ssum_r) + prod_r)));
        if (CNT_W'(k_r) + CNT_W'(1) == n_r) begin
          k_nxt     = '0;
          state_nxt = S_R_RD;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_B_RD;
        end
      end
      S_R_RD: state_nxt = S_R_HDR;
      S_R_HDR: begin
        ek_nxt    = tim_rd.exec;
        dl_nxt    = tim_rd.deadline;
        sw2_nxt   = {tim_rd.sw, 1'b0};
        idx_nxt   = tim_rd.idx;
        bk_nxt    = blk_q[RESP_W-1:0];
        acc_nxt   = '0;
        j_nxt     = '0;
        state_nxt = S_I_RD;
      end
      S_I_RD: begin
        tim_ra    = IDX_W'(j_r);
        state_nxt = S_I_ADD;
      end
      S_I_ADD: begin
        acc_nxt = clamp(WIDE_W'(acc_r) + WIDE_W'(tim_rd.exec) + WIDE_W'(sw2_r));
        if (j_r == CNT_W'(k_r)) begin
          state_nxt = S_T_START;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_I_RD;
        end
      end
      S_T_START: begin
        t_nxt     = r_cur;
        acc_nxt   = clamp(WIDE_W'(ek_r) + WIDE_W'(sw2_r) + WIDE_W'(bk_r));
        j_nxt     = '0;
        state_nxt = (k_r == '0) ? S_CHECK : S_J_RD;
      end
      S_J_RD: begin
        tim_ra    = IDX_W'(j_r);
        state_nxt = S_J_DIV;
      end
      S_J_DIV: begin
        div_start = 1'b1;
        esw_nxt   = ESW_W'(tim_rd.exec) + ESW_W'(sw2_r);
        state_nxt = S_J_WAIT;
      end
      S_J_WAIT: begin
        if (div_done) begin
          prod_nxt  = WIDE_W'(ceil_q) * WIDE_W'(esw_r);
          state_nxt = S_J_ADD;
        end
      end
      S_J_ADD: begin
        acc_nxt = clamp(WIDE_W'(acc_r) + prod_r);
        if (j_r + CNT_W'(1) == CNT_W'(k_r)) begin
          state_nxt = S_CHECK;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_J_RD;
        end
      end
      S_CHECK: begin
        if ((r_cur > RESP_W'(dl_r)) || !(t_r < r_cur)) begin
          ov_nxt    = 1'b1;
          on_nxt    = task_num(idx_r);
          ors_nxt   = r_cur;
          obk_nxt   = bk_r;
          omiss_nxt = r_cur > RESP_W'(dl_r);
          olast_nxt = CNT_W'(k_r) + CNT_W'(1) == n_r;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_T_START;
        end
      end
      S_EMIT: begin
        if (out_if.ready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            n_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_R_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    new_tim_r <= new_tim_nxt;
    new_sus_r <= new_sus_nxt;
    last_r    <= last_nxt;
    mx_r      <= mx_nxt;
    ssum_r    <= ssum_nxt;
    prod_r    <= prod_nxt;
    ek_r      <= ek_nxt;
    dl_r      <= dl_nxt;
    sw2_r     <= sw2_nxt;
    idx_r     <= idx_nxt;
    bk_r      <= bk_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    esw_r     <= esw_nxt;
    on_r      <= on_nxt;
    ors_r     <= ors_nxt;
    obk_r     <= obk_nxt;
    omiss_r   <= omiss_nxt;
    olast_r   <= olast_nxt;
  end
endmodule

// File: design/rta_chk.sv
// Port-level checker for response_time_analysis and its bind statement.
// Depends on rta_pkg.
module rta_chk import rta_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NUM_W-1:0]  out_task_number,
  input logic [RESP_W-1:0] out_response_time,
  input logic              out_last_result
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_response_time)
                               && $stable(out_task_number))
    else $error("stalled result beat changed");

  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> !out_valid && in_ready)
    else $error("result after final beat of task set");
endmodule

bind response_time_analysis rta_chk u_rta_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_task_number(out_if.task_number),
  .out_response_time(out_if.response_time),
  .out_last_result(out_if.last_result)
);
